// ----- design/bdm_pkg.sv -----
// Shared types and constants of the battery discharge monitor.
package bdm_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_RECORD_MODE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOG_EVERY     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RECORD_STEP   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RECORD_PERIOD = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_VOLT_OFFSET   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_END_THRESHOLD = 3'd5;
  localparam int unsigned CfgDataW = 16;

  // Register reset values
  localparam logic        RecordModeRst   = 1'b1;
  localparam logic        LogEveryRst     = 1'b0;
  localparam logic [7:0]  RecordStepRst   = 8'd1;
  localparam logic [15:0] RecordPeriodRst = 16'd120;
  localparam logic [8:0]  VoltOffsetRst   = 9'd8;
  localparam logic [10:0] EndThresholdRst = 11'd282;

  // State reset values
  localparam logic [7:0]  LastCodeRst = 8'd255;

  // Record modes
  localparam logic MODE_TIME  = 1'b0;
  localparam logic MODE_VOLTS = 1'b1;

  // Stream widths
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 88;
  localparam int unsigned OutUserW = 2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DECIDE
  } seq_state_e;

  // Modulo unit request and status
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } mod_stat_t;

endpackage

// ----- design/battery_discharge_monitor.sv -----
// Top level of the battery discharge monitor: registers, sequencer and output stage.
// Takes one sample (8-bit code, 32-bit elapsed seconds) at a time and returns one
// result per sample until the voltage falls below the end threshold; that sample is
// returned with finished and record set, and every later sample is accepted and
// dropped until reset. In voltage mode or with log_every set, an accepted sample goes
// straight to the decide state; in time mode it waits first in the divide state for
// the bit-serial modulo unit, which computes elapsed mod period one quotient bit per
// cycle. The input is not ready while a sample is at work; a result waiting in the
// output register does not hold off the next sample, only the loading of its result.
module battery_discharge_monitor
  import bdm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // Sample stream in
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // adc_code[7:0], elapsed_s[39:8]
  // Result stream out
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // sample_index[31:0], code_out[39:32],
                                              // volts_q8[51:40], elapsed_out[83:52], 0
  output logic [OutUserW-1:0] m_axis_tuser    // record[0], finished[1]
);

  // Configuration registers
  logic        record_mode_q;
  logic        log_every_q;
  logic [7:0]  record_step_q;
  logic [15:0] record_period_q;
  logic [8:0]  volt_offset_q;
  logic [10:0] end_threshold_q;

  // Block state
  logic [7:0]  last_code_q, last_code_d;
  logic [31:0] last_time_q, last_time_d;
  logic [31:0] sample_cnt_q, sample_cnt_d;
  logic        test_done_q, test_done_d;

  // Sample under work
  logic [7:0]  code_q, code_d;
  logic [31:0] elapsed_q, elapsed_d;

  seq_state_e state_q, state_d;

  // Output register
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic [OutUserW-1:0] out_user_q, out_user_d;

  mod_req_t  mod_req;
  mod_stat_t mod_stat;

  logic        in_acc;
  logic        out_free;
  logic [10:0] code_x5;
  logic [11:0] volts;
  logic [8:0]  drop;
  logic        fire_time;
  logic        fire_volts;
  logic        fire;
  logic        done;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      record_mode_q   <= RecordModeRst;
      log_every_q     <= LogEveryRst;
      record_step_q   <= RecordStepRst;
      record_period_q <= RecordPeriodRst;
      volt_offset_q   <= VoltOffsetRst;
      end_threshold_q <= EndThresholdRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RECORD_MODE:   record_mode_q   <= cfg_wdata_i[0];
        CFG_LOG_EVERY:     log_every_q     <= cfg_wdata_i[0];
        CFG_RECORD_STEP:   record_step_q   <= cfg_wdata_i[7:0];
        CFG_RECORD_PERIOD: record_period_q <= cfg_wdata_i[15:0];
        CFG_VOLT_OFFSET:   volt_offset_q   <= cfg_wdata_i[8:0];
        CFG_END_THRESHOLD: end_threshold_q <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Convert code to volts and evaluate the record rules
  assign code_x5    = {1'b0, code_q, 2'b00} + {3'b000, code_q};
  assign volts      = {1'b0, code_x5} + {{3{volt_offset_q[8]}}, volt_offset_q};
  assign drop       = {1'b0, last_code_q} - {1'b0, code_q};
  assign fire_volts = $signed(drop) >= $signed({1'b0, record_step_q});
  assign fire_time  = (record_period_q != '0) && mod_stat.rem_zero
                      && (elapsed_q != last_time_q);
  assign fire       = (record_mode_q == MODE_TIME) ? fire_time : fire_volts;
  assign done       = $signed(volts) < $signed({1'b0, end_threshold_q});

  // Modulo unit request
  assign mod_req.start    = in_acc && !test_done_q && (record_mode_q == MODE_TIME)
                            && !log_every_q;
  assign mod_req.dividend = s_axis_tdata[39:8];
  assign mod_req.divisor  = record_period_q;

  bdm_moddiv u_moddiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .stat_o (mod_stat)
  );

  // Sequence one sample: take, reduce, decide
  always_comb begin
    state_d      = state_q;
    code_d       = code_q;
    elapsed_d    = elapsed_q;
    last_code_d  = last_code_q;
    last_time_d  = last_time_q;
    sample_cnt_d = sample_cnt_q;
    test_done_d  = test_done_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_data_d   = out_data_q;
    out_user_d   = out_user_q;
    unique case (state_q)
      ST_IDLE: begin
        // Drop samples once the test has ended
        if (in_acc && !test_done_q) begin
          code_d    = s_axis_tdata[7:0];
          elapsed_d = s_axis_tdata[39:8];
          state_d   = mod_req.start ? ST_DIV : ST_DECIDE;
        end
      end
      ST_DIV: begin
        if (mod_stat.done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // Hold until the output register can take the result
        if (out_free) begin
          if (!log_every_q && fire) begin
            last_code_d = code_q;
            last_time_d = elapsed_q;
          end
          if (done) begin
            test_done_d = 1'b1;
          end
          sample_cnt_d = sample_cnt_q + 32'd1;
          out_valid_d  = 1'b1;
          out_data_d   = {4'b0000, elapsed_q, volts, code_q, sample_cnt_q};
          out_user_d   = {done, log_every_q || fire || done};
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      last_code_q  <= LastCodeRst;
      last_time_q  <= '0;
      sample_cnt_q <= '0;
      test_done_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      last_code_q  <= last_code_d;
      last_time_q  <= last_time_d;
      sample_cnt_q <= sample_cnt_d;
      test_done_q  <= test_done_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q     <= code_d;
    elapsed_q  <= elapsed_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ----- design/bdm_moddiv.sv -----
// Bit-serial restoring modulo unit: one quotient bit per cycle.
module bdm_moddiv
  import bdm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mod_req_t  req_i,
  output mod_stat_t stat_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] dvd_q, dvd_d;
  logic [15:0] div_q, div_d;
  logic [15:0] rem_q, rem_d;
  logic [16:0] shifted;
  logic [16:0] diff;

  // Shift in the next dividend bit and try the subtract
  assign shifted = {rem_q, dvd_q[31]};
  assign diff    = shifted - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 5'd31;
      dvd_d  = req_i.dividend;
      div_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[30:0], 1'b0};
      if (shifted >= {1'b0, div_q}) begin
        rem_d = diff[15:0];
      end else begin
        rem_d = shifted[15:0];
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign stat_o.done     = done_q;
  assign stat_o.rem_zero = (rem_q == '0);

endmodule

// ----- design/bdm_checker.sv -----
// Port-level checks of the battery discharge monitor and their binding.
module bdm_checker
  import bdm_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [OutUserW-1:0] m_axis_tuser
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // A finishing sample is always recorded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tuser[1] || m_axis_tuser[0])
    else $error("finished result without record");

  // Nothing follows the finishing result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser[1] |=> !m_axis_tvalid)
    else $error("result after end of test");

  // Pad bits of the result stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[87:84] == 4'b0000)
    else $error("result pad bits set");

endmodule

bind battery_discharge_monitor bdm_checker u_bdm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- test/tb.sv -----
// Self-checking testbench of the battery discharge monitor.
`timescale 1ns / 1ps

module tb;
  import bdm_pkg::*;

  localparam int StuckLimit = 2000;
  localparam int DrainCycles = 60;

  // Register settings in force
  typedef struct {
    logic              mode;
    logic              log_all;
    logic [7:0]        step;
    logic [15:0]       period;
    logic signed [8:0] offset;
    logic [10:0]       threshold;
  } monitor_cfg_t;

  // One sample request, laid out as on s_axis_tdata
  typedef struct packed {
    logic [31:0] elapsed;
    logic [7:0]  code;
  } sample_t;

  // One logged result
  typedef struct {
    logic        record;
    logic        finished;
    logic [31:0] index;
    logic [7:0]  code;
    logic [11:0] volts;
    logic [31:0] elapsed;
  } result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;

  battery_discharge_monitor u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // adc_code[7:0], elapsed_s[39:8]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // sample_index, code_out, volts_q8, elapsed_out, 0
    .m_axis_tuser  (m_axis_tuser)    // record[0], finished[1]
  );

  sample_t      pending_samples[$];
  result_t      expected_results[$];
  monitor_cfg_t live_cfg;
  logic [7:0]   rec_code = LastCodeRst;
  logic [31:0]  rec_time = '0;
  logic [31:0]  sample_total = '0;
  logic         run_over = 1'b0;
  int           mismatch_count = 0;
  int           stuck_cycles = 0;
  bit           src_steady = 1'b0;
  bit           snk_steady = 1'b0;
  sample_t      src_req;
  int           src_gap = 0;
  int           snk_stall = 0;
  int           snk_draw;

  // Clock and reset
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Print one mismatch and count it
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
    mismatch_count++;
  endtask

  // Work out the result of one accepted sample and advance the monitor state
  function automatic void predict_sample(sample_t s);
    result_t r;
    int      volts;
    int      drop;
    logic    hit;
    if (run_over) return;
    volts = int'(s.code) * 5 + int'(live_cfg.offset);
    hit = 1'b0;
    if (live_cfg.mode == MODE_TIME) begin
      if (live_cfg.period != 0)
        hit = (s.elapsed % live_cfg.period == 0) && (s.elapsed != rec_time);
    end else begin
      drop = int'(rec_code) - int'(s.code);
      hit = drop >= int'(live_cfg.step);
    end
    // Conditional records move the reference point, log-every ones do not
    if (!live_cfg.log_all && hit) begin
      rec_code = s.code;
      rec_time = s.elapsed;
    end
    r.finished = volts < int'(live_cfg.threshold);
    if (r.finished) run_over = 1'b1;
    r.record = live_cfg.log_all || hit || r.finished;
    r.index = sample_total;
    sample_total = sample_total + 1;
    r.code = s.code;
    r.volts = volts[11:0];
    r.elapsed = s.elapsed;
    expected_results.push_back(r);
  endfunction

  // Compare one result against the oldest expectation
  task automatic check_result(input logic [OutDataW-1:0] data,
                              input logic [OutUserW-1:0] user);
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result, sample_index", 64'(data[31:0]), 64'd0);
      return;
    end
    want = expected_results.pop_front();
    if (user[0] !== want.record)
      report_mismatch("record", 64'(user[0]), 64'(want.record));
    if (user[1] !== want.finished)
      report_mismatch("finished", 64'(user[1]), 64'(want.finished));
    if (data[31:0] !== want.index)
      report_mismatch("sample_index", 64'(data[31:0]), 64'(want.index));
    if (data[39:32] !== want.code)
      report_mismatch("code_out", 64'(data[39:32]), 64'(want.code));
    if (data[51:40] !== want.volts)
      report_mismatch("volts_q8", 64'(data[51:40]), 64'(want.volts));
    if (data[83:52] !== want.elapsed)
      report_mismatch("elapsed_out", 64'(data[83:52]), 64'(want.elapsed));
    if (data[87:84] !== 4'd0)
      report_mismatch("tdata padding", 64'(data[87:84]), 64'd0);
  endtask

  // Drive sample requests from the pending queue
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_sample(src_req);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          s_axis_tvalid <= 1'b0;
          src_gap <= src_gap - 1;
        end else if (pending_samples.size() != 0) begin
          src_req = pending_samples.pop_front();
          s_axis_tdata <= src_req;
          s_axis_tvalid <= 1'b1;
          src_gap <= src_steady ? 0 : $urandom_range(0, 14);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Take results, stalling a random number of cycles after each
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      snk_stall <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      check_result(m_axis_tdata, m_axis_tuser);
      snk_draw = snk_steady ? 0 : $urandom_range(0, 14);
      snk_stall <= snk_draw;
      m_axis_tready <= (snk_draw == 0);
    end else if (snk_stall > 1) begin
      snk_stall <= snk_stall - 1;
    end else begin
      snk_stall <= 0;
      m_axis_tready <= 1'b1;
    end
  end

  // Count cycles in which nothing moves
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= StuckLimit);
    $display("Verification failed");
    $finish;
  end

  // Hold until every request is taken and every result has come
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // Write all six registers, one per cycle
  task automatic program_settings(input monitor_cfg_t c);
    logic [CfgIdxW-1:0] idx;
    for (int i = 0; i < 6; i++) begin
      idx = i[CfgIdxW-1:0];
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      case (idx)
        CFG_RECORD_MODE:   cfg_wdata_i <= {15'd0, c.mode};
        CFG_LOG_EVERY:     cfg_wdata_i <= {15'd0, c.log_all};
        CFG_RECORD_STEP:   cfg_wdata_i <= {8'd0, c.step};
        CFG_RECORD_PERIOD: cfg_wdata_i <= c.period;
        CFG_VOLT_OFFSET:   cfg_wdata_i <= {7'd0, c.offset};
        default:           cfg_wdata_i <= {5'd0, c.threshold};
      endcase
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    live_cfg = c;
    @(negedge clk_i);
  endtask

  function automatic monitor_cfg_t make_cfg(logic mode, logic log_all, int step, int period,
                                            int offset, int threshold);
    monitor_cfg_t c;
    c.mode = mode;
    c.log_all = log_all;
    c.step = step[7:0];
    c.period = period[15:0];
    c.offset = offset[8:0];
    c.threshold = threshold[10:0];
    return c;
  endfunction

  function automatic void queue_sample(int code, longint elapsed);
    sample_t s;
    s.code = code[7:0];
    s.elapsed = elapsed[31:0];
    pending_samples.push_back(s);
  endfunction

  // One random setting, then a discharge-like run of samples under it
  task automatic run_random_phase(input bit force_pause);
    monitor_cfg_t c;
    int           off;
    int           lo;
    int           vmin;
    int           code;
    int           n;
    int           pause_at;
    longint       t;
    c.mode = 1'($urandom_range(0, 1));
    c.log_all = ($urandom_range(0, 5) == 0);
    case ($urandom_range(0, 3))
      0:       c.step = 8'($urandom_range(1, 255));
      1:       c.step = 8'd255;
      default: c.step = 8'($urandom_range(1, 4));
    endcase
    case ($urandom_range(0, 4))
      0:       c.period = 16'($urandom_range(1, 65535));
      1:       c.period = 16'hFFFF;
      default: c.period = 16'($urandom_range(1, 16));
    endcase
    // Keep every voltage at or above the threshold so the run goes on
    off = int'($urandom_range(0, 511)) - 256;
    lo = (off < 0) ? (4 - off) / 5 : 0;
    if ($urandom_range(0, 1) == 1) lo = $urandom_range(lo, 255);
    vmin = lo * 5 + off;
    c.offset = off[8:0];
    c.threshold = 11'(($urandom_range(0, 2) == 0) ? vmin : $urandom_range(0, vmin));
    program_settings(c);
    src_steady = ($urandom_range(0, 3) == 0);
    snk_steady = ($urandom_range(0, 3) == 0);
    code = $urandom_range(lo, 255);
    case ($urandom_range(0, 2))
      0:       t = 0;
      1:       t = 64'hFFFF_FF00 + $urandom_range(0, 255);
      default: t = longint'($urandom());
    endcase
    n = $urandom_range(55, 75);
    pause_at = (force_pause || $urandom_range(0, 3) == 0) ? n / 2 : -1;
    for (int k = 0; k < n; k++) begin
      if (k == pause_at) wait_drained();
      if ($urandom_range(0, 7) == 0) begin
        queue_sample($urandom_range(lo, 255), longint'($urandom()));
      end else begin
        // Drift the code down with the odd rise, advance time in small steps
        if ($urandom_range(0, 5) == 0) code = code + $urandom_range(0, 8);
        else code = code - $urandom_range(0, 3);
        if (code > 255) code = 255;
        if (code < lo) code = lo;
        case ($urandom_range(0, 4))
          0:       t = (t / c.period + 1) * c.period;
          1:       t = t;
          default: t = t + $urandom_range(1, 3);
        endcase
        t = t & 64'hFFFF_FFFF;
        queue_sample(code, t);
      end
    end
    wait_drained();
  endtask

  // Stimulus
  initial begin
    live_cfg = make_cfg(RecordModeRst, LogEveryRst, int'(RecordStepRst),
                        int'(RecordPeriodRst), int'($signed(VoltOffsetRst)),
                        int'(EndThresholdRst));
    @(posedge rst_ni);
    @(negedge clk_i);

    // Reset settings: voltage mode, step of one
    queue_sample(200, 0);
    queue_sample(200, 1);
    queue_sample(199, 2);
    queue_sample(255, 64'hFFFF_FFFF);
    wait_drained();

    // Time mode, repeated time and voltage equal to the threshold
    program_settings(make_cfg(MODE_TIME, 1'b0, 1, 3, 255, 255));
    queue_sample(0, 0);
    queue_sample(255, 3);
    queue_sample(128, 3);
    queue_sample(7, 4);
    queue_sample(1, 6);
    wait_drained();

    // Zero period never records; most negative offset
    program_settings(make_cfg(MODE_TIME, 1'b0, 1, 0, -256, 4));
    queue_sample(52, 0);
    queue_sample(60, 64'h8000_0000);
    wait_drained();

    // Largest period at the top of the time range
    program_settings(make_cfg(MODE_TIME, 1'b0, 1, 65535, 0, 0));
    queue_sample(100, 64'hFFFF_FFFF);
    queue_sample(100, 64'hFFFE_FFFF);
    wait_drained();

    // Log every sample
    program_settings(make_cfg(MODE_VOLTS, 1'b1, 1, 120, 0, 0));
    queue_sample(100, 7);
    queue_sample(90, 8);
    wait_drained();

    // Zero step records whenever the code has not risen
    program_settings(make_cfg(MODE_VOLTS, 1'b0, 0, 120, 0, 0));
    queue_sample(90, 9);
    queue_sample(91, 10);
    queue_sample(90, 11);
    wait_drained();

    // Largest step
    program_settings(make_cfg(MODE_VOLTS, 1'b0, 255, 120, 0, 0));
    queue_sample(0, 12);
    wait_drained();

    for (int p = 0; p < 25; p++) run_random_phase(p == 0);

    // End the test with the lowest voltage, then drop a few more samples
    program_settings(make_cfg(MODE_VOLTS, 1'b0, 1, 120, -256, 2047));
    src_steady = 1'b0;
    snk_steady = 1'b0;
    queue_sample(0, 13);
    for (int k = 0; k < 5; k++)
      queue_sample($urandom_range(0, 255), longint'($urandom()));
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- battery_discharge_monitor.f -----
design/bdm_pkg.sv
design/bdm_moddiv.sv
design/battery_discharge_monitor.sv
design/bdm_checker.sv
test/tb.sv
